// ----- design/alr_pkg.sv -----
// Shared types and constants of the audio loop recorder.
// Used by alr_ctrl, alr_store and audio_loop_recorder_core; no dependencies.
package alr_pkg;

    localparam int CAPACITY   = 131072;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int LEN_W      = $clog2(CAPACITY + 1);
    localparam int SAMPLE_W   = 16;
    localparam int CTRL_W     = 7;
    localparam int OUT_LEN_W  = 18;

    localparam logic [CTRL_W-1:0] TRIGGER_RESET = CTRL_W'(127);

    localparam logic [1:0] OP_SAMPLE      = 2'd0;
    localparam logic [1:0] OP_TOGGLE_REC  = 2'd1;
    localparam logic [1:0] OP_TOGGLE_LOOP = 2'd2;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_PRIME = 2'd1,
        MODE_READY = 2'd2,
        MODE_LOOP  = 2'd3
    } mode_t;

    // At most one access to the loop store per transaction.
    typedef struct packed {
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
    } mem_req_t;

    // Result fields that are known at accept time.
    typedef struct packed {
        logic                 use_mem;
        logic [SAMPLE_W-1:0]  sample;
        mode_t                mode;
        logic                 full;
        logic [OUT_LEN_W-1:0] length;
    } item_t;

endpackage

// ----- design/alr_store.sv -----
// Loop store: single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on alr_pkg for depth, widths and the request struct.
module alr_store (
    input  logic                          aclk,
    input  alr_pkg::mem_req_t             req,
    output logic [alr_pkg::SAMPLE_W-1:0]  rd_data
);

    logic [alr_pkg::SAMPLE_W-1:0] mem [alr_pkg::CAPACITY];
    logic [alr_pkg::SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Hold read data until the next read so a stalled result keeps its sample.
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/alr_ctrl.sv -----
// Mode sequencer of the audio loop recorder: mode, length, play pointer, full flag.
// Depends on alr_pkg; issues at most one loop store access per accepted transaction.
module alr_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [alr_pkg::CTRL_W-1:0]    cfg_wdata,
    input  logic                          item_en,
    input  logic [1:0]                    opcode,
    input  logic [alr_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [alr_pkg::CTRL_W-1:0]    control_value,
    output alr_pkg::mem_req_t             mem_req,
    output alr_pkg::item_t                item
);

    localparam int LW = alr_pkg::LEN_W;
    localparam int AW = alr_pkg::ADDR_W;

    logic [alr_pkg::CTRL_W-1:0] trigger_reg;
    alr_pkg::mode_t             mode_reg, mode_next;
    logic [LW-1:0]              len_reg, len_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic                       full_reg, full_next;

    logic          fire;
    logic [AW-1:0] ptr_use;
    logic [LW-1:0] ptr_inc;
    logic [LW+alr_pkg::OUT_LEN_W-1:0] len_wide;

    assign fire    = control_value >= trigger_reg;
    assign ptr_use = ({{(LW-AW){1'b0}}, ptr_reg} >= len_reg) ? '0 : ptr_reg;
    assign ptr_inc = {{(LW-AW){1'b0}}, ptr_use} + LW'(1);

    always_comb begin
        mode_next = mode_reg;
        len_next  = len_reg;
        ptr_next  = ptr_reg;
        full_next = full_reg;
        mem_req   = '{rd_en: 1'b0, rd_addr: ptr_use, wr_en: 1'b0,
                      wr_addr: len_reg[AW-1:0], wr_data: sample_in};
        item.use_mem = 1'b0;
        item.sample  = '0;
        unique case (opcode)
            alr_pkg::OP_SAMPLE: begin
                if (mode_reg == alr_pkg::MODE_LOOP) begin
                    if (len_reg != '0) begin
                        mem_req.rd_en = item_en;
                        item.use_mem  = 1'b1;
                        ptr_next      = (ptr_inc >= len_reg) ? '0 : ptr_inc[AW-1:0];
                    end
                end else begin
                    item.sample = sample_in;
                    if (mode_reg == alr_pkg::MODE_PRIME) begin
                        if (len_reg < LW'(alr_pkg::CAPACITY)) begin
                            mem_req.wr_en = item_en;
                            len_next      = len_reg + LW'(1);
                        end else begin
                            full_next = 1'b1;
                        end
                    end
                end
            end
            alr_pkg::OP_TOGGLE_REC: begin
                if (fire) begin
                    if (mode_reg == alr_pkg::MODE_PASS || mode_reg == alr_pkg::MODE_READY) begin
                        len_next  = '0;
                        ptr_next  = '0;
                        mode_next = alr_pkg::MODE_PRIME;
                    end else if (mode_reg == alr_pkg::MODE_PRIME) begin
                        mode_next = alr_pkg::MODE_READY;
                    end
                end
            end
            alr_pkg::OP_TOGGLE_LOOP: begin
                if (fire) begin
                    if (mode_reg == alr_pkg::MODE_READY || mode_reg == alr_pkg::MODE_PRIME) begin
                        mode_next = alr_pkg::MODE_LOOP;
                    end else if (mode_reg == alr_pkg::MODE_LOOP) begin
                        mode_next = alr_pkg::MODE_READY;
                    end
                end
            end
            default: begin
            end
        endcase
        len_wide    = {{alr_pkg::OUT_LEN_W{1'b0}}, len_next};
        item.mode   = mode_next;
        item.full   = full_next;
        item.length = len_wide[alr_pkg::OUT_LEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_reg <= alr_pkg::TRIGGER_RESET;
            mode_reg    <= alr_pkg::MODE_PASS;
            len_reg     <= '0;
            ptr_reg     <= '0;
            full_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                trigger_reg <= cfg_wdata;
            end
            if (item_en) begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
                ptr_reg  <= ptr_next;
                full_reg <= full_next;
            end
        end
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(alr_pkg::CAPACITY))
        else $error("loop length beyond store capacity");

    a_ptr_in_loop: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg == '0 || {{(LW-AW){1'b0}}, ptr_reg} < len_reg)
        else $error("play pointer outside recorded loop");

    a_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |=> full_reg)
        else $error("store full flag cleared without reset");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("read and write issued by one transaction");

endmodule

// ----- design/audio_loop_recorder_core.sv -----
// Top level of the audio loop recorder: control sequencer, loop store, output stage.
// Depends on alr_pkg, alr_ctrl and alr_store.
//
// Usage:
//   Input transactions arrive on s_t*: s_tuser carries the opcode (sample, toggle
//   record, toggle loop), s_tdata the sample and the controller value. Every input
//   transaction yields exactly one result transaction on m_t*, in order, carrying
//   the output sample, the mode after the item, the sticky store-full flag and the
//   recorded loop length.
//   cfg_we/cfg_wdata write the trigger level; write it only while the block is idle.
//   An accepted input passes the read stage (synchronous read of the loop store),
//   then the output register, which drives m_tvalid. Throughput: one transaction
//   per cycle unless m_tready stalls the output; the loop store sees at most one
//   read or one write per transaction, and mode, length and pointer update in the accept cycle.
//   A recorded entry is always written at least one transaction before any loop
//   read can reach it, since a toggle must come between recording and playback.
//   Reset (aresetn low, synchronous): passthrough mode, length, pointer and full
//   flag cleared, trigger level 127, both pipeline stages emptied. The store
//   contents are not cleared; only recorded entries are ever played.
//   Stall: when m_tready is low a valid output register holds; the read stage holds its
//   result and store read data, and s_tready drops once both are occupied.
module audio_loop_recorder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,   // trigger_level
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [15:0] sample_in, [22:16] control_value, [23] zero
    input  logic [1:0]  s_tuser,     // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata      // [15:0] sample_out, [17:16] mode, [18] store_full,
                                     // [36:19] loop_length, [39:37] zero
);

    logic                         item_en;
    alr_pkg::mem_req_t            mem_req;
    alr_pkg::item_t               item;
    logic [alr_pkg::SAMPLE_W-1:0] rd_data;

    // Read stage: waits for the store read data.
    logic           p1_valid_reg;
    alr_pkg::item_t p1_item_reg;
    // Output stage.
    logic           out_valid_reg;
    logic [39:0]    out_data_reg;

    logic                         out_adv;
    logic                         p1_adv;
    logic [alr_pkg::SAMPLE_W-1:0] p1_sample;

    assign out_adv  = !out_valid_reg || m_tready;
    assign p1_adv   = p1_valid_reg && out_adv;
    assign s_tready = !p1_valid_reg || out_adv;
    assign item_en  = s_tvalid && s_tready;

    alr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .item_en       (item_en),
        .opcode        (s_tuser),
        .sample_in     (s_tdata[15:0]),
        .control_value (s_tdata[22:16]),
        .mem_req       (mem_req),
        .item          (item)
    );

    alr_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Pick the looped sample from the store or the echoed sample.
    assign p1_sample = p1_item_reg.use_mem ? rd_data : p1_item_reg.sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                p1_valid_reg <= item_en;
            end
            if (out_adv) begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        if (item_en) begin
            p1_item_reg <= item;
        end
        if (p1_adv) begin
            out_data_reg <= {3'b000, p1_item_reg.length, p1_item_reg.full,
                             p1_item_reg.mode, p1_sample};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> p1_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    a_read_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.rd_en |=> p1_valid_reg && p1_item_reg.use_mem)
        else $error("store read issued without a read-stage entry");

    a_p1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && !out_adv |=> p1_valid_reg && $stable(p1_item_reg))
        else $error("read stage lost its entry under stall");

endmodule

// ----- tb/audio_loop_recorder_core_tb.sv -----
// Self-checking testbench for audio_loop_recorder_core: directed table and random stream
// traffic, scored against the table's typed results or an in-bench loop recorder model.
// Depends on alr_pkg and the audio_loop_recorder_core RTL.
module audio_loop_recorder_core_tb;

    // Opcode 3 has no name in the package; it must act as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NUM_DIR = 25;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD = 400;

    // One result transaction: the fields of m_tdata, from the sample field up.
    typedef struct packed {
        logic [15:0]    smp;
        alr_pkg::mode_t mode;
        logic           full;
        logic [17:0]    len;
    } loop_result_t;

    // One row of the directed table; res is used only where typed is set.
    typedef struct {
        logic [1:0]   op;
        logic [15:0]  smp;
        logic [6:0]   ctrl;
        bit           typed;
        loop_result_t res;
    } dir_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // Model state of the recorder, updated once per accepted input transaction.
    logic [6:0]     trig_level = 7'd127;
    alr_pkg::mode_t cur_mode = alr_pkg::MODE_PASS;
    int             rec_len = 0;
    int             play_pos = 0;
    logic           store_full = 1'b0;
    logic [15:0]    rec_mem [int];

    loop_result_t expected_q [$];
    int           mismatches = 0;

    // Idle rates in percent (tx per item, rx per cycle); long receiver hold-off request.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    dir_row_t dir_rows [NUM_DIR] = '{
        '{alr_pkg::OP_SAMPLE, 16'h7FFF, 7'd0, 1'b1,
          '{16'h7FFF, alr_pkg::MODE_PASS, 1'b0, 18'd0}},
        '{alr_pkg::OP_SAMPLE, 16'h8000, 7'd127, 1'b1,
          '{16'h8000, alr_pkg::MODE_PASS, 1'b0, 18'd0}},
        // toggle below the trigger level: nothing moves
        '{alr_pkg::OP_TOGGLE_REC, 16'hFFFF, 7'd126, 1'b1,
          '{16'h0000, alr_pkg::MODE_PASS, 1'b0, 18'd0}},
        // toggle loop is ignored in passthrough
        '{alr_pkg::OP_TOGGLE_LOOP, 16'h0000, 7'd127, 1'b1,
          '{16'h0000, alr_pkg::MODE_PASS, 1'b0, 18'd0}},
        '{OP_UNUSED, 16'h1234, 7'd127, 1'b1,
          '{16'h0000, alr_pkg::MODE_PASS, 1'b0, 18'd0}},
        '{alr_pkg::OP_TOGGLE_REC, 16'h0000, 7'd127, 1'b1,
          '{16'h0000, alr_pkg::MODE_PRIME, 1'b0, 18'd0}},
        '{alr_pkg::OP_TOGGLE_LOOP, 16'h0000, 7'd127, 1'b1,
          '{16'h0000, alr_pkg::MODE_LOOP, 1'b0, 18'd0}},
        // empty loop plays zeros
        '{alr_pkg::OP_SAMPLE, 16'h5555, 7'd0, 1'b1,
          '{16'h0000, alr_pkg::MODE_LOOP, 1'b0, 18'd0}},
        '{alr_pkg::OP_TOGGLE_LOOP, 16'h0000, 7'd127, 1'b1,
          '{16'h0000, alr_pkg::MODE_READY, 1'b0, 18'd0}},
        '{alr_pkg::OP_TOGGLE_REC, 16'h0000, 7'd127, 1'b1,
          '{16'h0000, alr_pkg::MODE_PRIME, 1'b0, 18'd0}},
        '{alr_pkg::OP_SAMPLE, 16'h7FFF, 7'd0, 1'b1,
          '{16'h7FFF, alr_pkg::MODE_PRIME, 1'b0, 18'd1}},
        '{alr_pkg::OP_SAMPLE, 16'h8000, 7'd0, 1'b1,
          '{16'h8000, alr_pkg::MODE_PRIME, 1'b0, 18'd2}},
        '{alr_pkg::OP_SAMPLE, 16'h0001, 7'd0, 1'b1,
          '{16'h0001, alr_pkg::MODE_PRIME, 1'b0, 18'd3}},
        '{alr_pkg::OP_TOGGLE_REC, 16'h0000, 7'd0, 1'b1,
          '{16'h0000, alr_pkg::MODE_PRIME, 1'b0, 18'd3}},
        '{alr_pkg::OP_TOGGLE_REC, 16'h0000, 7'd127, 1'b1,
          '{16'h0000, alr_pkg::MODE_READY, 1'b0, 18'd3}},
        '{alr_pkg::OP_SAMPLE, 16'hAAAA, 7'd0, 1'b1,
          '{16'hAAAA, alr_pkg::MODE_READY, 1'b0, 18'd3}},
        '{alr_pkg::OP_TOGGLE_LOOP, 16'h0000, 7'd127, 1'b1,
          '{16'h0000, alr_pkg::MODE_LOOP, 1'b0, 18'd3}},
        // playback through the wrap point
        '{alr_pkg::OP_SAMPLE, 16'h0000, 7'd0, 1'b0,
          '{16'h0000, alr_pkg::MODE_PASS, 1'b0, 18'd0}},
        '{alr_pkg::OP_SAMPLE, 16'hFFFF, 7'd0, 1'b0,
          '{16'h0000, alr_pkg::MODE_PASS, 1'b0, 18'd0}},
        '{alr_pkg::OP_SAMPLE, 16'h1111, 7'd0, 1'b0,
          '{16'h0000, alr_pkg::MODE_PASS, 1'b0, 18'd0}},
        '{alr_pkg::OP_SAMPLE, 16'h2222, 7'd0, 1'b0,
          '{16'h0000, alr_pkg::MODE_PASS, 1'b0, 18'd0}},
        // record toggle is ignored while looping
        '{alr_pkg::OP_TOGGLE_REC, 16'h0000, 7'd127, 1'b1,
          '{16'h0000, alr_pkg::MODE_LOOP, 1'b0, 18'd3}},
        '{alr_pkg::OP_TOGGLE_LOOP, 16'h0000, 7'd127, 1'b1,
          '{16'h0000, alr_pkg::MODE_READY, 1'b0, 18'd3}},
        '{alr_pkg::OP_TOGGLE_LOOP, 16'h0000, 7'd127, 1'b1,
          '{16'h0000, alr_pkg::MODE_LOOP, 1'b0, 18'd3}},
        // playback resumes where it stopped
        '{alr_pkg::OP_SAMPLE, 16'h3333, 7'd0, 1'b0,
          '{16'h0000, alr_pkg::MODE_PASS, 1'b0, 18'd0}}
    };

    audio_loop_recorder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Advance the recorder model by one input transaction and return its result.
    function automatic loop_result_t apply_item(logic [1:0] op, logic [15:0] smp,
                                                logic [6:0] ctrl);
        loop_result_t r;
        logic fire;
        fire = (ctrl >= trig_level);
        r.smp = '0;
        case (op)
            alr_pkg::OP_SAMPLE: begin
                if (cur_mode == alr_pkg::MODE_LOOP) begin
                    if (rec_len != 0 && rec_len <= alr_pkg::CAPACITY) begin
                        if (play_pos >= rec_len) play_pos = 0;
                        r.smp = rec_mem[play_pos];
                        play_pos++;
                        if (play_pos >= rec_len) play_pos = 0;
                    end
                end else begin
                    r.smp = smp;
                    if (cur_mode == alr_pkg::MODE_PRIME) begin
                        if (rec_len < alr_pkg::CAPACITY) begin
                            rec_mem[rec_len] = smp;
                            rec_len++;
                        end else begin
                            store_full = 1'b1;
                        end
                    end
                end
            end
            alr_pkg::OP_TOGGLE_REC: begin
                if (fire) begin
                    if (cur_mode == alr_pkg::MODE_PASS || cur_mode == alr_pkg::MODE_READY) begin
                        rec_len = 0;
                        play_pos = 0;
                        cur_mode = alr_pkg::MODE_PRIME;
                    end else if (cur_mode == alr_pkg::MODE_PRIME) begin
                        cur_mode = alr_pkg::MODE_READY;
                    end
                end
            end
            alr_pkg::OP_TOGGLE_LOOP: begin
                if (fire) begin
                    if (cur_mode == alr_pkg::MODE_READY || cur_mode == alr_pkg::MODE_PRIME)
                        cur_mode = alr_pkg::MODE_LOOP;
                    else if (cur_mode == alr_pkg::MODE_LOOP)
                        cur_mode = alr_pkg::MODE_READY;
                end
            end
            default: ;
        endcase
        r.mode = cur_mode;
        r.full = store_full;
        r.len  = 18'(rec_len);
        return r;
    endfunction

    // Offer one input transaction, hold it until accepted, then queue its expected result.
    task automatic offer_item(input logic [1:0] op, input logic [15:0] smp,
                              input logic [6:0] ctrl, input bit typed,
                              input loop_result_t typed_res);
        loop_result_t pred;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, ctrl, smp};
        do @(posedge aclk); while (!s_tready);
        pred = apply_item(op, smp, ctrl);
        expected_q.push_back(typed ? typed_res : pred);
    endtask

    task automatic offer_plain(input logic [1:0] op, input logic [15:0] smp,
                               input logic [6:0] ctrl);
        offer_item(op, smp, ctrl, 1'b0, '0);
    endtask

    // Mostly fire toggles, with a share of random (often sub-threshold) control values.
    function automatic logic [6:0] pick_ctrl();
        if ($urandom_range(0, 99) < 75) return 7'($urandom_range(trig_level, 127));
        return 7'($urandom_range(0, 127));
    endfunction

    // Random traffic: sample bursts between toggles, plus no-op opcodes.
    task automatic run_random(input int n_items);
        int sent;
        int pick;
        int burst;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                burst = $urandom_range(1, 12);
                repeat (burst) offer_plain(alr_pkg::OP_SAMPLE, 16'($urandom), 7'($urandom));
                sent += burst;
            end else begin
                if (pick < 75)
                    offer_plain(alr_pkg::OP_TOGGLE_REC, 16'($urandom), pick_ctrl());
                else if (pick < 94)
                    offer_plain(alr_pkg::OP_TOGGLE_LOOP, 16'($urandom), pick_ctrl());
                else
                    offer_plain(OP_UNUSED, 16'($urandom), 7'($urandom));
                sent++;
            end
        end
    endtask

    // Drop valid and wait until every result is back and the pipeline is empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_trigger(input logic [6:0] level);
        cfg_we    <= 1'b1;
        cfg_wdata <= level;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        trig_level = level;
    endtask

    // Result side: random ready, or a long hold-off when the stimulus asks for one.
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Score each result transaction against the oldest expectation.
    always @(posedge aclk) begin
        loop_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction: m_tdata %h", m_tdata);
                mismatches++;
            end else begin
                exp_res = expected_q.pop_front();
                if (m_tdata[15:0] !== exp_res.smp) begin
                    $error("sample_out: expected %h, got %h", exp_res.smp, m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[17:16] !== exp_res.mode) begin
                    $error("mode: expected %0d, got %0d", exp_res.mode, m_tdata[17:16]);
                    mismatches++;
                end
                if (m_tdata[18] !== exp_res.full) begin
                    $error("store_full: expected %0d, got %0d", exp_res.full, m_tdata[18]);
                    mismatches++;
                end
                if (m_tdata[36:19] !== exp_res.len) begin
                    $error("loop_length: expected %0d, got %0d", exp_res.len, m_tdata[36:19]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    initial begin
        for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_trigger(7'd127);

        // Directed table at the reset trigger level.
        tx_idle_pct = 25;
        rx_idle_pct = 72;
        for (int i = 0; i < NUM_DIR; i++)
            offer_item(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].ctrl,
                       dir_rows[i].typed, dir_rows[i].res);
        drain();

        // Slow receiver, mid trigger level.
        write_trigger(7'd64);
        run_random(220);
        drain();

        // Slow sender, every toggle fires.
        tx_idle_pct = 72;
        rx_idle_pct = 25;
        write_trigger(7'd0);
        run_random(220);
        drain();

        // Full rate: long receiver hold-off first so the input backs up,
        // then random traffic at full speed.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_trigger(7'd127);
        hold_requests++;
        run_random(210);
        drain();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/alr_pkg.sv
design/alr_store.sv
design/alr_ctrl.sv
design/audio_loop_recorder_core.sv
tb/audio_loop_recorder_core_tb.sv
